// ----- rtl/core/pkgsd_pkg.sv -----
package pkgsd_pkg;

    // Item kinds carried on the input tuser field
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_FRAME = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Frame geometry
    localparam int FRAME_LEN  = 32;
    localparam int HEADER_LEN = 5;
    localparam int SCREENS    = 10;
    localparam int ROM_LEN    = 32;
    localparam int HEAD_LEN   = 21;
    localparam int TAIL_LEN   = ROM_LEN - HEAD_LEN;
    localparam int BLANK_IDX  = 9;
    localparam int BLANK_LEAD = 3;
    localparam logic [5:0] POS_MAX = 6'd63;

    // Screen groups: menus 1, 8, 9 lock everything; menus 2..7 and blank lock digits
    localparam logic [SCREENS-1:0] LOCK_ALL_MASK   = 10'h181;
    localparam logic [SCREENS-1:0] LOCK_DIGIT_MASK = 10'h27E;

    // Panel key codes
    localparam logic [7:0] KEY_NONE   = 8'h00;
    localparam logic [7:0] KEY_MENU   = 8'h45;
    localparam logic [7:0] KEY_HASH   = 8'h38;
    localparam logic [7:0] KEY_TWO    = 8'h25;
    localparam logic [7:0] KEY_SEVEN  = 8'h17;
    localparam logic [7:0] KEY_SIX    = 8'h36;
    localparam logic [7:0] KEY_FIVE   = 8'h26;
    localparam logic [7:0] KEY_OK     = 8'h75;
    localparam logic [7:0] KEY_ONE    = 8'h15;
    localparam logic [7:0] KEY_EIGHT  = 8'h27;
    localparam logic [7:0] KEY_NINE   = 8'h37;
    localparam logic [7:0] KEY_STAT_A = 8'hB0;
    localparam logic [7:0] KEY_STAT_B = 8'hAF;

    // Sequence steps
    localparam logic [2:0] SEQ_IDLE  = 3'd0;
    localparam logic [2:0] SEQ_START = 3'd1;
    localparam logic [2:0] SEQ_FINAL = 3'd5;

    localparam logic [7:0] STEP_TIMEOUT_RST = 8'd3;

    // Common header of screens 0..8
    localparam logic [7:0] SCREEN_HEAD [HEAD_LEN] = '{
        8'h11, 8'hA1, 8'h21, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'hF5, 8'hD8,
        8'hDC, 8'hA4, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h11, 8'h20
    };

    // Per-screen text after the header, menus 1..9
    localparam logic [7:0] SCREEN_TAIL [BLANK_IDX][TAIL_LEN] = '{
        '{8'h20, 8'h20, 8'h31, 8'h2E, 8'hD9, 8'hB9, 8'hE4, 8'hA1, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h32, 8'h2E, 8'hED, 8'hBB, 8'hE3, 8'hA3, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h33, 8'h2E, 8'hF2, 8'hF4, 8'hE3, 8'hAC, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h34, 8'h2E, 8'hDE, 8'hAE, 8'hE3, 8'hBC, 8'h20, 8'h20, 8'h20},
        '{8'h35, 8'h2E, 8'hF1, 8'hF1, 8'hF3, 8'hA3, 8'hA1, 8'hEA, 8'hF3, 8'hB7, 8'h20},
        '{8'h20, 8'h20, 8'h36, 8'h2E, 8'hE9, 8'hE9, 8'hE5, 8'hCD, 8'h20, 8'h20, 8'h20},
        '{8'h37, 8'h2E, 8'hDE, 8'hAE, 8'hD9, 8'hEE, 8'hF1, 8'hC2, 8'hEE, 8'hA1, 8'h20},
        '{8'h20, 8'h38, 8'h2E, 8'h4E, 8'h65, 8'h74, 8'h77, 8'h6F, 8'h72, 8'h6B, 8'h20},
        '{8'h39, 8'h2E, 8'hEF, 8'hB9, 8'hE5, 8'hFF, 8'h20, 8'h55, 8'h53, 8'h42, 8'h20}
    };

    // Byte of a ROM screen at a frame position
    function automatic logic [7:0] rom_byte(input logic [3:0] scr, input logic [4:0] pos);
        logic [4:0] tail_pos;
        logic [7:0] val;
        tail_pos = pos - 5'(HEAD_LEN);
        if (scr == 4'(BLANK_IDX)) begin
            val = (pos < 5'(BLANK_LEAD)) ? SCREEN_HEAD[pos] : 8'h20;
        end else if (pos < 5'(HEAD_LEN)) begin
            val = SCREEN_HEAD[pos];
        end else begin
            val = SCREEN_TAIL[scr][tail_pos[3:0]];
        end
        return val;
    endfunction

    // Key expected after a given sequence step
    function automatic logic [7:0] next_seq_key(input logic [2:0] prog);
        logic [7:0] k;
        case (prog)
            3'd1:    k = KEY_HASH;
            3'd2:    k = KEY_TWO;
            3'd3:    k = KEY_SEVEN;
            3'd4:    k = KEY_SIX;
            3'd5:    k = KEY_FIVE;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    typedef struct packed {
        logic ok;
        logic digits;
    } perm_t;

    typedef struct packed {
        logic pulse;
        logic direct;
    } seq_status_t;

endpackage

// ----- rtl/core/pkgsd_frame_match.sv -----
module pkgsd_frame_match (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_fire,
    input  logic [7:0]          frame_byte,
    input  logic                frame_last,
    output pkgsd_pkg::perm_t    perm_cur,
    output pkgsd_pkg::perm_t    perm_next
);
    import pkgsd_pkg::*;

    logic [5:0]         pos_reg, pos_next;
    logic [SCREENS-1:0] mask_reg, mask_next;
    logic               hdr_reg, hdr_next;
    perm_t              perm_reg, perm_new;
    logic [SCREENS-1:0] miss;
    logic [SCREENS-1:0] mask_upd;
    logic               hdr_upd;
    logic [5:0]         pos_upd;

    // Compare this byte against every screen at once
    always_comb begin
        miss = '0;
        for (int s = 0; s < SCREENS; s++) begin
            miss[s] = (rom_byte(4'(s), pos_reg[4:0]) != frame_byte);
        end
    end

    always_comb begin
        mask_upd = mask_reg;
        hdr_upd  = hdr_reg;
        if (!pos_reg[5]) begin
            if (pos_reg < 6'(FRAME_LEN)) begin
                mask_upd = mask_reg & ~miss;
            end
            if (pos_reg < 6'(HEADER_LEN) && miss[0]) begin
                hdr_upd = 1'b0;
            end
        end
        pos_upd = (pos_reg < POS_MAX) ? pos_reg + 6'd1 : pos_reg;

        perm_new  = perm_reg;
        pos_next  = pos_reg;
        mask_next = mask_reg;
        hdr_next  = hdr_reg;
        if (byte_fire) begin
            pos_next  = pos_upd;
            mask_next = mask_upd;
            hdr_next  = hdr_upd;
            if (frame_last) begin
                if (pos_upd >= 6'(FRAME_LEN) && pos_upd >= 6'(HEADER_LEN) && hdr_upd) begin
                    if ((mask_upd & LOCK_ALL_MASK) != '0) begin
                        perm_new = '{ok: 1'b0, digits: 1'b0};
                    end else if ((mask_upd & LOCK_DIGIT_MASK) != '0) begin
                        perm_new = '{ok: 1'b1, digits: 1'b0};
                    end else begin
                        perm_new = '{ok: 1'b1, digits: 1'b1};
                    end
                end
                // rearm for the next frame
                pos_next  = '0;
                mask_next = '1;
                hdr_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            mask_reg <= '1;
            hdr_reg  <= 1'b1;
            perm_reg <= '{ok: 1'b1, digits: 1'b1};
        end else begin
            pos_reg  <= pos_next;
            mask_reg <= mask_next;
            hdr_reg  <= hdr_next;
            perm_reg <= perm_new;
        end
    end

    assign perm_cur  = perm_reg;
    assign perm_next = perm_new;

endmodule

// ----- rtl/core/pkgsd_seq_detect.sv -----
module pkgsd_seq_detect (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    key_fire,
    input  logic                    tick_fire,
    input  logic [7:0]              key_code,
    input  logic [7:0]              step_timeout,
    output pkgsd_pkg::seq_status_t  status_next,
    output logic                    direct_cur
);
    import pkgsd_pkg::*;

    logic [7:0]        elapsed_reg, elapsed_next;
    logic [7:0]        last_reg, last_next;
    logic [2:0]        prog_reg, prog_next;
    logic              direct_reg, direct_next;
    logic              pulse;
    logic signed [9:0] gap;
    logic              in_time;
    logic              step_ok;

    always_comb begin
        gap     = signed'({2'b00, elapsed_reg}) - signed'({2'b00, last_reg});
        in_time = gap < signed'({2'b00, step_timeout});
        step_ok = in_time && prog_reg >= SEQ_START && prog_reg <= SEQ_FINAL
                  && key_code == next_seq_key(prog_reg);

        elapsed_next = elapsed_reg;
        last_next    = last_reg;
        prog_next    = prog_reg;
        direct_next  = direct_reg;
        pulse        = 1'b0;

        if (key_fire && key_code != KEY_STAT_A && key_code != KEY_STAT_B) begin
            if (key_code == KEY_MENU) begin
                elapsed_next = 8'd1;
                last_next    = 8'd1;
                prog_next    = SEQ_START;
            end else if (step_ok && prog_reg < SEQ_FINAL) begin
                last_next = elapsed_reg;
                prog_next = prog_reg + 3'd1;
            end else begin
                // wrong, late or final key: drop progress
                if (step_ok) begin
                    direct_next = 1'b1;
                    pulse       = 1'b1;
                end
                prog_next    = SEQ_IDLE;
                elapsed_next = '0;
                last_next    = '0;
            end
        end else if (tick_fire && elapsed_reg != 8'hFF) begin
            elapsed_next = elapsed_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            last_reg    <= '0;
            prog_reg    <= SEQ_IDLE;
            direct_reg  <= 1'b0;
        end else begin
            elapsed_reg <= elapsed_next;
            last_reg    <= last_next;
            prog_reg    <= prog_next;
            direct_reg  <= direct_next;
        end
    end

    assign status_next = '{pulse: pulse, direct: direct_next};
    assign direct_cur  = direct_reg;

endmodule

// ----- rtl/core/panel_key_gate_sequence_detector_top.sv -----
// Front-panel key gate. Words enter on the s_ channel as key presses, display
// frame bytes or timer ticks (kind in s_tuser) and each yields exactly one result
// word on the m_ channel, in order. A display frame of at least FRAME_LEN bytes
// whose header matches is checked against ten stored screens and sets the OK and
// digit key permissions at its last byte; keys are forwarded or dropped by those
// permissions and also step a six-key unlock sequence (menu, #, 2, 7, 6, 5) that
// must advance within step_timeout ticks per step. Completion gives a one-word
// unlock pulse and sets a sticky direct flag. Throughput is one word per clock
// while the result register drains: a word is captured in the input register,
// the screen compares and sequence update run in one combinational pass into
// the result register, which drives m_tvalid. The result register and
// the input register are separate: while a result waits, s_tready stays high
// only if the input register is empty; with both registers full and m_tready
// low the input stalls. Write step_timeout only while idle.
module panel_key_gate_sequence_detector_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_code, [15:8] frame_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        s_tlast,   // frame_last
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] forward_key, [1] unlock_pulse,
                                   // [2] direct_active, [3] ok_allowed,
                                   // [4] digits_allowed, [7:5] zero
    // step_timeout register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import pkgsd_pkg::*;

    // Input register
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [7:0]  in_key_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Result register
    logic        out_valid_reg;
    logic [7:0]  out_data_reg, out_data_next;

    logic [7:0]  step_timeout_reg;

    logic        advance;
    logic        fire;
    logic        key_fire;
    logic        byte_fire;
    logic        tick_fire;
    logic        fwd;
    perm_t       perm_cur;
    perm_t       perm_next;
    seq_status_t seq_status;
    logic        direct_cur;

    // Advance the pipe whenever the result slot is free or being drained
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    assign key_fire  = fire && in_op_reg == OP_KEY && in_key_reg != KEY_NONE;
    assign byte_fire = fire && in_op_reg == OP_FRAME;
    assign tick_fire = fire && in_op_reg == OP_TICK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_timeout_reg <= STEP_TIMEOUT_RST;
        end else if (cfg_we) begin
            step_timeout_reg <= cfg_wdata;
        end
    end

    // Capture a new word whenever the input slot opens
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser);
            in_key_reg  <= s_tdata[7:0];
            in_byte_reg <= s_tdata[15:8];
            in_last_reg <= s_tlast;
        end
    end

    pkgsd_frame_match u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_fire  (byte_fire),
        .frame_byte (in_byte_reg),
        .frame_last (in_last_reg),
        .perm_cur   (perm_cur),
        .perm_next  (perm_next)
    );

    pkgsd_seq_detect u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_fire     (key_fire),
        .tick_fire    (tick_fire),
        .key_code     (in_key_reg),
        .step_timeout (step_timeout_reg),
        .status_next  (seq_status),
        .direct_cur   (direct_cur)
    );

    // Drop OK and digit keys that the current screen does not permit
    always_comb begin
        fwd = key_fire;
        if (!perm_cur.ok && in_key_reg == KEY_OK) begin
            fwd = 1'b0;
        end
        if (!perm_cur.digits && (in_key_reg inside {KEY_ONE, KEY_EIGHT, KEY_NINE})) begin
            fwd = 1'b0;
        end
        out_data_next = {3'b000, perm_next.digits, perm_next.ok,
                         seq_status.direct, seq_status.pulse, fwd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // An unlock pulse always comes with the direct flag set
    a_pulse_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
        else $error("unlock pulse without direct flag");

    // Only key words can be forwarded
    a_fwd_key_only: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_op_reg != OP_KEY |=> !out_data_reg[0])
        else $error("non-key word forwarded");

    // The direct flag never clears once set
    a_direct_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        direct_cur |=> direct_cur)
        else $error("direct flag cleared");

    // Input stalls only when both stages are occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with a free stage");
`endif

endmodule

// ----- bench/panel_key_gate_sequence_detector_top_test.sv -----
module panel_key_gate_sequence_detector_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pkgsd_pkg::*;

    // One input word as the sender sees it
    typedef struct packed {
        op_t        op;
        logic [7:0] key;
        logic [7:0] fbyte;
        logic       last;
    } panel_word_t;

    // One result word, field by field
    typedef struct packed {
        logic forward;
        logic unlock;
        logic direct;
        logic ok;
        logic digits;
    } gate_verdict_t;

    // What the driver does with one queue entry
    typedef enum logic [1:0] {
        ENT_WORD  = 2'd0,
        ENT_CFG   = 2'd1,
        ENT_DRAIN = 2'd2
    } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        panel_word_t w;
        logic [7:0]  cfg;
    } stim_entry_t;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_WORDS = 380;
    localparam int TOTAL_WORDS = 1150;

    // Screens 1, 8, 9 lock both permissions; screens 2..7 and blank lock digits
    localparam logic [9:0] LOCK_BOTH   = 10'h181;
    localparam logic [9:0] LOCK_DIGITS = 10'h27E;

    // Bytes 0..20 shared by menu screens 1..9
    localparam logic [7:0] MENU_HEAD [21] = '{
        8'h11, 8'hA1, 8'h21, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'hF5, 8'hD8,
        8'hDC, 8'hA4, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h11, 8'h20
    };

    // Bytes 21..31 of menu screens 1..9
    localparam logic [7:0] MENU_TEXT [9][11] = '{
        '{8'h20, 8'h20, 8'h31, 8'h2E, 8'hD9, 8'hB9, 8'hE4, 8'hA1, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h32, 8'h2E, 8'hED, 8'hBB, 8'hE3, 8'hA3, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h33, 8'h2E, 8'hF2, 8'hF4, 8'hE3, 8'hAC, 8'h20, 8'h20, 8'h20},
        '{8'h20, 8'h20, 8'h34, 8'h2E, 8'hDE, 8'hAE, 8'hE3, 8'hBC, 8'h20, 8'h20, 8'h20},
        '{8'h35, 8'h2E, 8'hF1, 8'hF1, 8'hF3, 8'hA3, 8'hA1, 8'hEA, 8'hF3, 8'hB7, 8'h20},
        '{8'h20, 8'h20, 8'h36, 8'h2E, 8'hE9, 8'hE9, 8'hE5, 8'hCD, 8'h20, 8'h20, 8'h20},
        '{8'h37, 8'h2E, 8'hDE, 8'hAE, 8'hD9, 8'hEE, 8'hF1, 8'hC2, 8'hEE, 8'hA1, 8'h20},
        '{8'h20, 8'h38, 8'h2E, 8'h4E, 8'h65, 8'h74, 8'h77, 8'h6F, 8'h72, 8'h6B, 8'h20},
        '{8'h39, 8'h2E, 8'hEF, 8'hB9, 8'hE5, 8'hFF, 8'h20, 8'h55, 8'h53, 8'h42, 8'h20}
    };

    // Unlock keys that must follow the menu key, in order
    localparam logic [7:0] UNLOCK_KEYS [5] = '{KEY_HASH, KEY_TWO, KEY_SEVEN, KEY_SIX, KEY_FIVE};

    // Keys with a meaning of their own, empty report included
    localparam logic [7:0] NAMED_KEYS [13] = '{
        KEY_NONE, KEY_MENU, KEY_HASH, KEY_TWO, KEY_SEVEN, KEY_SIX, KEY_FIVE,
        KEY_OK, KEY_ONE, KEY_EIGHT, KEY_NINE, KEY_STAT_A, KEY_STAT_B
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    stim_entry_t   stim_q[$];
    gate_verdict_t exp_q[$];
    logic          stim_ready    = 1'b0;
    logic          in_hs         = 1'b0;
    int            words_queued  = 0;
    int            words_sent    = 0;
    int            words_checked = 0;
    int            err_count     = 0;
    int            idle_cycles   = 0;

    // Model state
    logic [7:0] mdl_timeout;
    logic [7:0] mdl_elapsed;
    logic [7:0] mdl_last;
    logic [2:0] mdl_prog;
    logic       mdl_ok;
    logic       mdl_dig;
    logic       mdl_direct;
    logic [5:0] mdl_pos;
    logic [9:0] mdl_mask;
    logic       mdl_hdr;

    panel_key_gate_sequence_detector_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Byte of a stored screen at a frame position below 32
    function automatic logic [7:0] screen_byte(int s, int pos);
        logic [7:0] b;
        if (s == 9) begin
            b = (pos < 3) ? MENU_HEAD[pos] : 8'h20;
        end else if (pos < 21) begin
            b = MENU_HEAD[pos];
        end else begin
            b = MENU_TEXT[s][pos - 21];
        end
        return b;
    endfunction

    function automatic void mdl_reset();
        mdl_timeout = STEP_TIMEOUT_RST;
        mdl_elapsed = '0;
        mdl_last    = '0;
        mdl_prog    = '0;
        mdl_ok      = 1'b1;
        mdl_dig     = 1'b1;
        mdl_direct  = 1'b0;
        mdl_pos     = '0;
        mdl_mask    = '1;
        mdl_hdr     = 1'b1;
    endfunction

    function automatic logic mdl_seq_key(logic [7:0] k);
        int   gap;
        logic hit;
        logic done;
        done = 1'b0;
        hit  = 1'b0;
        if (k == KEY_STAT_A || k == KEY_STAT_B) begin
            return 1'b0;
        end
        if (k == KEY_MENU) begin
            mdl_elapsed = 8'd1;
            mdl_last    = 8'd1;
            mdl_prog    = 3'd1;
            return 1'b0;
        end
        gap = int'(mdl_elapsed) - int'(mdl_last);
        if (gap < int'(mdl_timeout) && mdl_prog >= 3'd1 && mdl_prog <= 3'd5) begin
            hit = (k == UNLOCK_KEYS[mdl_prog - 3'd1]);
        end
        if (hit) begin
            if (mdl_prog < 3'd5) begin
                mdl_last = mdl_elapsed;
                mdl_prog = mdl_prog + 3'd1;
                return 1'b0;
            end
            mdl_direct = 1'b1;
            done       = 1'b1;
        end
        mdl_prog    = '0;
        mdl_elapsed = '0;
        mdl_last    = '0;
        return done;
    endfunction

    function automatic void mdl_frame(logic [7:0] b, logic last);
        int pos;
        pos = int'(mdl_pos);
        if (pos < 32) begin
            if (pos < FRAME_LEN) begin
                for (int s = 0; s < 10; s++) begin
                    if (screen_byte(s, pos) != b) begin
                        mdl_mask[s] = 1'b0;
                    end
                end
            end
            if (pos < HEADER_LEN && screen_byte(0, pos) != b) begin
                mdl_hdr = 1'b0;
            end
        end
        if (mdl_pos < 6'd63) begin
            mdl_pos = mdl_pos + 6'd1;
        end
        if (!last) begin
            return;
        end
        if (int'(mdl_pos) >= FRAME_LEN && int'(mdl_pos) >= HEADER_LEN && mdl_hdr) begin
            if ((mdl_mask & LOCK_BOTH) != '0) begin
                mdl_ok  = 1'b0;
                mdl_dig = 1'b0;
            end else if ((mdl_mask & LOCK_DIGITS) != '0) begin
                mdl_ok  = 1'b1;
                mdl_dig = 1'b0;
            end else begin
                mdl_ok  = 1'b1;
                mdl_dig = 1'b1;
            end
        end
        mdl_pos  = '0;
        mdl_mask = '1;
        mdl_hdr  = 1'b1;
    endfunction

    function automatic gate_verdict_t mdl_step(panel_word_t w);
        gate_verdict_t v;
        v = '0;
        case (w.op)
            OP_KEY: begin
                if (w.key != KEY_NONE) begin
                    v.unlock  = mdl_seq_key(w.key);
                    v.forward = 1'b1;
                    if (!mdl_ok && w.key == KEY_OK) begin
                        v.forward = 1'b0;
                    end
                    if (!mdl_dig && (w.key inside {KEY_ONE, KEY_EIGHT, KEY_NINE})) begin
                        v.forward = 1'b0;
                    end
                end
            end
            OP_FRAME: mdl_frame(w.fbyte, w.last);
            OP_TICK: begin
                if (mdl_elapsed != 8'hFF) begin
                    mdl_elapsed = mdl_elapsed + 8'd1;
                end
            end
            default: ;
        endcase
        v.direct = mdl_direct;
        v.ok     = mdl_ok;
        v.digits = mdl_dig;
        return v;
    endfunction

    function automatic int send_idle_pct();
        if (words_sent < PHASE_WORDS) return 37;
        if (words_sent < 2 * PHASE_WORDS) return 54;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_sent < PHASE_WORDS) return 54;
        if (words_sent < 2 * PHASE_WORDS) return 37;
        return 0;
    endfunction

    task automatic push_word(op_t op, logic [7:0] key, logic [7:0] fb, logic last);
        stim_entry_t e;
        e.kind    = ENT_WORD;
        e.w.op    = op;
        e.w.key   = key;
        e.w.fbyte = fb;
        e.w.last  = last;
        e.cfg     = '0;
        stim_q.push_back(e);
        words_queued++;
    endtask

    task automatic push_cfg(logic [7:0] value);
        stim_entry_t e;
        e.kind = ENT_CFG;
        e.w    = '0;
        e.cfg  = value;
        stim_q.push_back(e);
    endtask

    task automatic push_drain();
        stim_entry_t e;
        e.kind = ENT_DRAIN;
        e.w    = '0;
        e.cfg  = '0;
        stim_q.push_back(e);
    endtask

    task automatic push_key(logic [7:0] k);
        push_word(OP_KEY, k, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) begin
            push_word(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // Menu key, then the five unlock keys with up to max_gap ticks before each
    task automatic push_unlock(int max_gap);
        push_key(KEY_MENU);
        for (int i = 0; i < 5; i++) begin
            push_ticks($urandom_range(max_gap));
            push_key(UNLOCK_KEYS[i]);
        end
    endtask

    // Frame of len bytes following screen s; the byte at flip_pos is spoiled
    task automatic push_screen(int s, int len, int flip_pos);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            b = (p < 32) ? screen_byte(s, p) : 8'($urandom);
            if (p == flip_pos) begin
                b = b ^ 8'h5A;
            end
            push_word(OP_FRAME, 8'($urandom), b, p == len - 1);
        end
    endtask

    task automatic push_key_probe();
        push_key(KEY_OK);
        push_key(KEY_ONE);
        push_key(KEY_EIGHT);
        push_key(KEY_NINE);
        push_key(KEY_FIVE);
    endtask

    initial begin
        int r;
        // basic keys and an unused kind
        push_key_probe();
        push_key(KEY_NONE);
        push_word(OP_NONE, 8'($urandom), 8'($urandom), 1'b1);
        // unlock in time, with status keys in between, and too late
        push_unlock(0);
        push_key(KEY_MENU);
        push_key(KEY_HASH);
        push_key(KEY_STAT_A);
        push_key(KEY_TWO);
        push_key(KEY_STAT_B);
        push_key(KEY_SEVEN);
        push_key(KEY_SIX);
        push_key(KEY_FIVE);
        push_key(KEY_MENU);
        push_ticks(3);
        push_key(KEY_HASH);
        push_key(KEY_MENU);
        push_key(KEY_HASH);
        push_key(KEY_SEVEN);
        // every stored screen, then the permissions it leaves
        for (int s = 0; s < 10; s++) begin
            push_screen(s, 32, -1);
            push_key_probe();
        end
        push_screen(0, 32, -1);
        push_screen(4, 20, -1);
        push_key_probe();
        push_screen(6, 32, 2);
        push_key_probe();
        push_screen(0, 32, 25);
        push_key_probe();
        push_screen(7, 40, -1);
        push_key_probe();
        push_screen(9, 32, 31);
        push_key_probe();
        push_screen(8, 70, -1);
        push_key_probe();
        push_drain();
        // wide timeout with a saturated tick count
        push_cfg(8'd255);
        push_key(KEY_MENU);
        push_ticks(258);
        push_key(KEY_HASH);
        push_key(KEY_TWO);
        push_key(KEY_SEVEN);
        push_key(KEY_SIX);
        push_key(KEY_FIVE);
        // zero timeout never lets the sequence advance
        push_cfg(8'd0);
        push_unlock(0);
        push_cfg(8'd1);
        push_unlock(0);
        push_key(KEY_MENU);
        push_ticks(1);
        push_key(KEY_HASH);
        push_cfg(8'd3);
        push_unlock(4);
        push_unlock(2);
        push_cfg(8'd2);
        while (words_queued < TOTAL_WORDS) begin
            r = $urandom_range(99);
            if (r < 35) begin
                if ($urandom_range(3) == 0) begin
                    push_key(8'($urandom));
                end else begin
                    push_key(NAMED_KEYS[$urandom_range(12)]);
                end
            end else if (r < 58) begin
                push_ticks(1);
            end else if (r < 72) begin
                push_word(OP_FRAME, 8'($urandom), 8'($urandom), $urandom_range(7) == 0);
            end else if (r < 77) begin
                push_word(OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
            end else if (r < 92) begin
                push_unlock(3);
            end else begin
                push_screen($urandom_range(9), $urandom_range(28, 36), -1);
            end
        end
        stim_ready = 1'b1;
    end

    // Driver: hold a word until it is taken, write config only when idle
    always @(negedge aclk) begin : drive
        stim_entry_t e;
        logic        nxt_valid;
        logic        nxt_we;
        nxt_valid = s_tvalid;
        nxt_we    = 1'b0;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_tvalid || in_hs) begin
            nxt_valid = 1'b0;
            if (stim_q.size() > 0) begin
                e = stim_q[0];
                case (e.kind)
                    ENT_WORD: begin
                        if ($urandom_range(99) >= send_idle_pct()) begin
                            nxt_valid = 1'b1;
                            s_tuser   <= e.w.op;
                            s_tdata   <= {e.w.fbyte, e.w.key};
                            s_tlast   <= e.w.last;
                            void'(stim_q.pop_front());
                            words_sent++;
                        end
                    end
                    ENT_CFG: begin
                        if (exp_q.size() == 0) begin
                            nxt_we    = 1'b1;
                            cfg_wdata <= e.cfg;
                            void'(stim_q.pop_front());
                        end
                    end
                    ENT_DRAIN: begin
                        if (exp_q.size() == 0) begin
                            void'(stim_q.pop_front());
                        end
                    end
                    default: void'(stim_q.pop_front());
                endcase
            end
        end
        s_tvalid <= nxt_valid;
        cfg_we   <= nxt_we;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // Monitor: predict on input handshakes, check on output handshakes
    always @(posedge aclk) begin : watch
        panel_word_t   w;
        gate_verdict_t exp_v;
        gate_verdict_t got_v;
        logic          out_hs;
        if (!aresetn) begin
            in_hs = 1'b0;
            mdl_reset();
            exp_q.delete();
            idle_cycles = 0;
        end else begin
            in_hs  = s_tvalid && s_tready;
            out_hs = m_tvalid && m_tready;
            if (cfg_we) begin
                mdl_timeout = cfg_wdata;
            end
            if (in_hs) begin
                w.op    = op_t'(s_tuser);
                w.key   = s_tdata[7:0];
                w.fbyte = s_tdata[15:8];
                w.last  = s_tlast;
                exp_q.push_back(mdl_step(w));
            end
            if (out_hs) begin
                got_v.forward = m_tdata[0];
                got_v.unlock  = m_tdata[1];
                got_v.direct  = m_tdata[2];
                got_v.ok      = m_tdata[3];
                got_v.digits  = m_tdata[4];
                if (exp_q.size() == 0) begin
                    $error("result word with nothing expected: m_tdata %0h", m_tdata);
                    err_count++;
                end else begin
                    exp_v = exp_q.pop_front();
                    if (got_v.forward !== exp_v.forward) begin
                        $error("forward_key expected %0d actual %0d",
                               exp_v.forward, got_v.forward);
                        err_count++;
                    end
                    if (got_v.unlock !== exp_v.unlock) begin
                        $error("unlock_pulse expected %0d actual %0d",
                               exp_v.unlock, got_v.unlock);
                        err_count++;
                    end
                    if (got_v.direct !== exp_v.direct) begin
                        $error("direct_active expected %0d actual %0d",
                               exp_v.direct, got_v.direct);
                        err_count++;
                    end
                    if (got_v.ok !== exp_v.ok) begin
                        $error("ok_allowed expected %0d actual %0d",
                               exp_v.ok, got_v.ok);
                        err_count++;
                    end
                    if (got_v.digits !== exp_v.digits) begin
                        $error("digits_allowed expected %0d actual %0d",
                               exp_v.digits, got_v.digits);
                        err_count++;
                    end
                end
                words_checked++;
            end
            if (in_hs || out_hs || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", STALL_LIMIT);
                $display("panel_key_gate_sequence_detector_top regression: fail");
                $finish;
            end
            if (stim_ready && stim_q.size() == 0 && !s_tvalid && exp_q.size() == 0) begin
                if (words_checked != words_sent) begin
                    $error("result count expected %0d actual %0d", words_sent, words_checked);
                    err_count++;
                end
                if (err_count == 0) begin
                    $display("panel_key_gate_sequence_detector_top regression: pass");
                end else begin
                    $display("panel_key_gate_sequence_detector_top regression: fail");
                end
                $finish;
            end
        end
    end

endmodule
